>>> hdl/tqla_pkg.sv
// Shared types, constants and helpers for the tabular Q-learning agent.
// No dependencies; imported by every module of the block.
`default_nettype none

package tqla_pkg;

    // Table geometry
    localparam int MAX_STATES  = 256;
    localparam int MAX_ACTIONS = 8;
    localparam int Q_DEPTH     = MAX_STATES * MAX_ACTIONS;
    localparam int ADDR_W      = $clog2(Q_DEPTH);
    localparam int STATE_W     = $clog2(MAX_STATES);
    localparam int ACT_LIMIT   = (MAX_ACTIONS < 8) ? MAX_ACTIONS : 8;

    // Arithmetic widths
    localparam int Q_W    = 32;
    localparam int WIDE_W = 40;

    // Epsilon decay (0.995) and floor (0.01) as 0.16 fractions
    localparam logic [15:0] EPS_DECAY = 16'd65208;
    localparam logic [15:0] EPS_FLOOR = 16'd655;

    // Item function codes
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_OUTCOME = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_LEARN_RATE    = 2'd0,
        REG_DISCOUNT      = 2'd1,
        REG_START_EXPLORE = 2'd2,
        REG_ACTIONS       = 2'd3
    } cfg_idx_t;

    typedef logic signed [Q_W-1:0] q_t;

    // Row scan request and result
    typedef struct packed {
        logic              go;
        logic [ADDR_W-1:0] base;
        logic [3:0]        count;
    } scan_req_t;

    typedef struct packed {
        logic       done;
        logic [2:0] idx;
        q_t         val;
    } scan_res_t;

    // Saturate a wide signed value to Q16.16
    function automatic q_t sat_q(input logic signed [WIDE_W-1:0] v);
        q_t r;
        if ((&v[WIDE_W-1:Q_W-1]) || !(|v[WIDE_W-1:Q_W-1])) begin
            r = v[Q_W-1:0];
        end else if (v[WIDE_W-1]) begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/tqla_qram.sv
// Q-value table: one write port, one read port, registered read data.
// Depends on tqla_pkg for depth and word width.
`default_nettype none

module tqla_qram
    import tqla_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire q_t                wdata,
    input  wire logic              ren,
    input  wire logic [ADDR_W-1:0] raddr,
    output q_t                     rdata
);

    q_t mem [Q_DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/tqla_scan.sv
// Row scanner: streams one Q row through the table read port and keeps the
// running maximum (start 0, ties go to the later index). Depends on tqla_pkg.
`default_nettype none

module tqla_scan
    import tqla_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire scan_req_t         req,
    input  wire q_t                rdata,
    output logic                   ren,
    output logic [ADDR_W-1:0]      raddr,
    output scan_res_t              res
);

    logic              active_reg;
    logic [3:0]        cnt_reg;
    logic [3:0]        count_reg;
    logic [ADDR_W-1:0] base_reg;
    logic              vld_reg;
    logic [2:0]        idx_d_reg;
    q_t                max_reg;
    logic [2:0]        arg_reg;
    logic              done_reg;

    // Issue one read per cycle until the row is covered
    assign ren   = active_reg && (cnt_reg < count_reg);
    assign raddr = base_reg + ADDR_W'(cnt_reg);

    assign res.done = done_reg;
    assign res.idx  = arg_reg;
    assign res.val  = max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            count_reg  <= '0;
            base_reg   <= '0;
            vld_reg    <= 1'b0;
            idx_d_reg  <= '0;
            max_reg    <= '0;
            arg_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
                count_reg  <= req.count;
                base_reg   <= req.base;
                vld_reg    <= 1'b0;
                max_reg    <= '0;
                arg_reg    <= '0;
            end
            else if (active_reg)
            begin
                // advance the read pointer
                vld_reg   <= (cnt_reg < count_reg);
                idx_d_reg <= cnt_reg[2:0];
                if (cnt_reg < count_reg)
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                end
                // compare the word that came back
                if (vld_reg && (rdata >= max_reg))
                begin
                    max_reg <= rdata;
                    arg_reg <= idx_d_reg;
                end
                // finish once the last word has been compared
                if ((cnt_reg == count_reg) && !vld_reg)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/tqla_update.sv
// Q-value update pipeline: Q + round(alpha * (r + round(gamma * max) - Q)),
// saturated to Q16.16. Four stages, one multiplier each in two of them.
// Depends on tqla_pkg.
`default_nettype none

module tqla_update
    import tqla_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               go,
    input  wire q_t                 old_q,
    input  wire q_t                 row_max,
    input  wire logic signed [15:0] reward,
    input  wire logic [15:0]        discount,
    input  wire logic [15:0]        learn_rate,
    output logic                    done,
    output q_t                      new_q
);

    logic [3:0]          vld_reg;
    q_t                  old_reg;
    logic signed [15:0]  rew_reg;
    logic signed [32:0]  g_reg;
    logic signed [34:0]  td_reg;
    logic signed [35:0]  d_reg;
    q_t                  new_q_reg;

    logic signed [48:0]  prod_g;
    logic signed [48:0]  prod_g_rnd;
    logic signed [34:0]  td_next;
    logic signed [51:0]  prod_d;
    logic signed [51:0]  prod_d_rnd;
    logic signed [WIDE_W-1:0] sum_wide;

    // Stage 1: gamma times next-row maximum, rounded
    assign prod_g     = $signed({1'b0, discount}) * row_max;
    assign prod_g_rnd = prod_g + 49'sd32768;

    // Stage 2: temporal difference
    assign td_next = $signed({{3{rew_reg[15]}}, rew_reg, 16'h0000})
                   + $signed({{2{g_reg[32]}}, g_reg})
                   - $signed({{3{old_reg[Q_W-1]}}, old_reg});

    // Stage 3: alpha times difference, rounded
    assign prod_d     = $signed({1'b0, learn_rate}) * td_reg;
    assign prod_d_rnd = prod_d + 52'sd32768;

    // Stage 4: add and saturate
    assign sum_wide = $signed({{(WIDE_W-Q_W){old_reg[Q_W-1]}}, old_reg})
                    + $signed({{(WIDE_W-36){d_reg[35]}}, d_reg});

    assign done  = vld_reg[3];
    assign new_q = new_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], go};
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            old_reg <= old_q;
            rew_reg <= reward;
            g_reg   <= prod_g_rnd[48:16];
        end
        td_reg    <= td_next;
        d_reg     <= prod_d_rnd[51:16];
        new_q_reg <= sat_q(sum_wide);
    end

endmodule

`default_nettype wire

>>> hdl/tabular_q_learning_agent_unit.sv
// Top level of the tabular Q-learning agent: item sequencer, registers and
// episode state. Uses tqla_pkg, tqla_qram, tqla_scan and tqla_update.
//
//  Port group   Direction  Handshake        Words
//  item in      in         start / busy     func, state_num, reward, terminal,
//                                           rand_explore, rand_action
//  result out   out        done (strobe)    action, explored, episode_over,
//                                           episode_reward, epsilon_now
//  config       in         cfg_we           cfg_index, cfg_wdata
//
// After reset the Q table is cleared one word a cycle, all Q_DEPTH (2048) words;
// busy stays high during the clear. Config writes are taken during the clear.
// One item at a time. With n actions in use, the result is registered at the
// accepting edge for a start that explores or a terminal outcome. A greedy start
// first scans the n words of the row; a non-terminal outcome scans the next-state
// row, reads the old Q value and runs the update, then explores or picks greedily
// (two row scans through the single table read port plus a four-stage update).
// The receiver cannot stall; done lasts one cycle.
`default_nettype none

module tabular_q_learning_agent_unit
    import tqla_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // item channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               func,
    input  wire logic [7:0]         state_num,
    input  wire logic signed [15:0] reward,
    input  wire logic               terminal,
    input  wire logic [15:0]        rand_explore,
    input  wire logic [2:0]         rand_action,
    // result channel
    output logic                    done,
    output logic [2:0]              action,
    output logic                    explored,
    output logic                    episode_over,
    output logic signed [31:0]      episode_reward,
    output logic [15:0]             epsilon_now,
    // configuration
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_wdata
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAXSCAN,
        ST_RDOLD,
        ST_UPDGO,
        ST_UPDWAIT,
        ST_GSCAN
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;

    // configuration
    logic [15:0]         learn_rate_reg;
    logic [15:0]         discount_reg;
    logic [3:0]          actions_reg;

    // agent state
    logic [STATE_W-1:0]  cur_state_reg;
    logic [2:0]          last_action_reg;
    logic [15:0]         epsilon_reg;
    q_t                  reward_sum_reg;

    // latched item
    logic [STATE_W-1:0]  sidx_reg;
    logic signed [15:0]  reward_reg;
    logic [15:0]         rexp_reg;
    logic [2:0]          ract_reg;
    q_t                  next_max_reg;

    // result
    logic                done_reg;
    logic [2:0]          action_reg;
    logic                explored_reg;
    logic                over_reg;
    logic                scan_go_reg;

    // internal nets
    logic                accept;
    logic [STATE_W-1:0]  sidx_in;
    logic [3:0]          n_act;
    logic [2:0]          n_max_idx;
    logic [2:0]          rand_pick_in;
    logic [2:0]          rand_pick_held;
    logic [31:0]         eps_prod;
    logic [15:0]         eps_dec;
    logic [15:0]         eps_next;
    logic signed [WIDE_W-1:0] rsum_wide;
    logic [ADDR_W-1:0]   cell_addr;
    logic [ADDR_W-1:0]   row_base;

    scan_req_t           scan_req;
    scan_res_t           scan_res;
    logic                scan_ren;
    logic [ADDR_W-1:0]   scan_raddr;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    q_t                  ram_wdata;
    logic                ram_ren;
    logic [ADDR_W-1:0]   ram_raddr;
    q_t                  ram_rdata;

    logic                upd_go;
    logic                upd_done;
    q_t                  upd_new_q;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Clamp the state index into the table
    always_comb
    begin
        if (32'(state_num) >= MAX_STATES)
        begin
            sidx_in = STATE_W'(MAX_STATES - 1);
        end
        else
        begin
            sidx_in = STATE_W'(state_num);
        end
    end

    // Number of actions in use: zero counts as one, capped at the table width
    always_comb
    begin
        if (actions_reg == 4'd0)
        begin
            n_act = 4'd1;
        end
        else if (32'(actions_reg) > ACT_LIMIT)
        begin
            n_act = 4'(ACT_LIMIT);
        end
        else
        begin
            n_act = actions_reg;
        end
    end
    assign n_max_idx      = 3'(n_act - 4'd1);
    assign rand_pick_in   = (rand_action > n_max_idx) ? n_max_idx : rand_action;
    assign rand_pick_held = (ract_reg > n_max_idx) ? n_max_idx : ract_reg;

    // Epsilon decay with floor
    assign eps_prod = epsilon_reg * EPS_DECAY + 32'd32768;
    assign eps_dec  = eps_prod[31:16];
    assign eps_next = (eps_dec < EPS_FLOOR) ? EPS_FLOOR : eps_dec;

    // Saturating episode total
    assign rsum_wide = $signed({{(WIDE_W-Q_W){reward_sum_reg[Q_W-1]}}, reward_sum_reg})
                     + $signed({{(WIDE_W-16){reward[15]}}, reward});

    // Table addresses
    assign cell_addr = ADDR_W'(cur_state_reg * MAX_ACTIONS + last_action_reg);
    assign row_base  = ADDR_W'(sidx_reg * MAX_ACTIONS);

    // Row scanner
    assign scan_req.go    = scan_go_reg;
    assign scan_req.base  = row_base;
    assign scan_req.count = n_act;

    tqla_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scan_req),
        .rdata (ram_rdata),
        .ren   (scan_ren),
        .raddr (scan_raddr),
        .res   (scan_res)
    );

    // Table port muxing: clear sweep, update write, scan or single read
    assign ram_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_UPDWAIT) && upd_done);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : cell_addr;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : upd_new_q;
    assign ram_ren   = scan_ren || (state_reg == ST_RDOLD);
    assign ram_raddr = scan_ren ? scan_raddr : cell_addr;

    tqla_qram u_qram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .ren   (ram_ren),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Update pipeline
    assign upd_go = (state_reg == ST_UPDGO);

    tqla_update u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (upd_go),
        .old_q      (ram_rdata),
        .row_max    (next_max_reg),
        .reward     (reward_reg),
        .discount   (discount_reg),
        .learn_rate (learn_rate_reg),
        .done       (upd_done),
        .new_q      (upd_new_q)
    );

    // Result ports
    assign done           = done_reg;
    assign action         = action_reg;
    assign explored       = explored_reg;
    assign episode_over   = over_reg;
    assign episode_reward = reward_sum_reg;
    assign epsilon_now    = epsilon_reg;

    // Sequencer, agent state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_addr_reg      <= '0;
            learn_rate_reg    <= 16'd6554;
            discount_reg      <= 16'd58982;
            actions_reg       <= 4'd8;
            cur_state_reg     <= '0;
            last_action_reg   <= '0;
            epsilon_reg       <= 16'd58982;
            reward_sum_reg    <= '0;
            sidx_reg          <= '0;
            reward_reg        <= '0;
            rexp_reg          <= '0;
            ract_reg          <= '0;
            next_max_reg      <= '0;
            done_reg          <= 1'b0;
            action_reg        <= '0;
            explored_reg      <= 1'b0;
            over_reg          <= 1'b0;
            scan_go_reg       <= 1'b0;
        end
        else
        begin
            done_reg    <= 1'b0;
            scan_go_reg <= 1'b0;

            case (state_reg)
                ST_CLEAR:
                begin
                    // sweep zeros through the table
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == ADDR_W'(Q_DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (accept)
                    begin
                        sidx_reg   <= sidx_in;
                        reward_reg <= reward;
                        rexp_reg   <= rand_explore;
                        ract_reg   <= rand_action;
                        if (func == FUNC_START)
                        begin
                            cur_state_reg  <= sidx_in;
                            reward_sum_reg <= '0;
                            if (rand_explore < epsilon_reg)
                            begin
                                action_reg      <= rand_pick_in;
                                last_action_reg <= rand_pick_in;
                                explored_reg    <= 1'b1;
                                over_reg        <= 1'b0;
                                done_reg        <= 1'b1;
                            end
                            else
                            begin
                                scan_go_reg <= 1'b1;
                                state_reg   <= ST_GSCAN;
                            end
                        end
                        else if (terminal)
                        begin
                            // episode end: total and decay only
                            reward_sum_reg <= sat_q(rsum_wide);
                            epsilon_reg    <= eps_next;
                            action_reg     <= '0;
                            explored_reg   <= 1'b0;
                            over_reg       <= 1'b1;
                            done_reg       <= 1'b1;
                        end
                        else
                        begin
                            reward_sum_reg <= sat_q(rsum_wide);
                            scan_go_reg    <= 1'b1;
                            state_reg      <= ST_MAXSCAN;
                        end
                    end
                end

                ST_MAXSCAN:
                begin
                    // hold until the next-state row maximum is known
                    if (scan_res.done)
                    begin
                        next_max_reg <= scan_res.val;
                        state_reg    <= ST_RDOLD;
                    end
                end

                ST_RDOLD:
                begin
                    state_reg <= ST_UPDGO;
                end

                ST_UPDGO:
                begin
                    state_reg <= ST_UPDWAIT;
                end

                ST_UPDWAIT:
                begin
                    // write back lands this cycle; then move to the next state
                    if (upd_done)
                    begin
                        cur_state_reg <= sidx_reg;
                        if (rexp_reg < epsilon_reg)
                        begin
                            action_reg      <= rand_pick_held;
                            last_action_reg <= rand_pick_held;
                            explored_reg    <= 1'b1;
                            over_reg        <= 1'b0;
                            done_reg        <= 1'b1;
                            state_reg       <= ST_IDLE;
                        end
                        else
                        begin
                            scan_go_reg <= 1'b1;
                            state_reg   <= ST_GSCAN;
                        end
                    end
                end

                ST_GSCAN:
                begin
                    // greedy pick from the current row
                    if (scan_res.done)
                    begin
                        action_reg      <= scan_res.idx;
                        last_action_reg <= scan_res.idx;
                        explored_reg    <= 1'b0;
                        over_reg        <= 1'b0;
                        done_reg        <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Register writes; the start value of epsilon loads epsilon directly
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_LEARN_RATE:    learn_rate_reg <= cfg_wdata;
                    REG_DISCOUNT:      discount_reg   <= cfg_wdata;
                    REG_START_EXPLORE: epsilon_reg    <= cfg_wdata;
                    REG_ACTIONS:       actions_reg    <= cfg_wdata[3:0];
                    default:           actions_reg    <= actions_reg;
                endcase
            end
        end
    end

endmodule

`default_nettype wire
